// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, sampled on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define TLPQ_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define TLPQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/tlpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpq_pkg
// types and codes shared by the two-level priority queue and its cells
// ----------------------------------------------------------------------------
package tlpq_pkg;

    // fixed index width covering the largest supported depth
    localparam int IDX_W = 6;

    // action codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_LIST   = 2'd2;

    // level codes
    localparam logic [1:0] LVL_ALL    = 2'd0;
    localparam logic [1:0] LVL_URGENT = 2'd1;
    localparam logic [1:0] LVL_NORMAL = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_BADLVL  = 3'd3;
    localparam logic [2:0] ST_NOMATCH = 3'd4;

    typedef struct packed {
        logic [15:0] id;
        logic [1:0]  lvl;
        logic [15:0] tag;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] pos;   // insert slot
        logic [IDX_W-1:0] tail;  // last occupied slot, for rotation
    } cell_ctrl_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] entry_id;
        logic [1:0]  entry_level;
        logic [15:0] entry_tag;
        logic [5:0]  position;
        logic [6:0]  occupancy;
        logic        last;
    } result_t;

endpackage

// ===== hw/rtl/two_level_priority_queue.sv =====
// ----------------------------------------------------------------------------
// two_level_priority_queue
// bounded queue with urgent and normal levels built as a chain of slot cells
// ----------------------------------------------------------------------------
// usage:
//   s_* channel takes one command transaction: s_tuser holds the action
//   (insert, remove head, list), s_tdata holds level and tag.
//   m_* channel returns result transactions; m_tlast marks the final result
//   of a command. insert and remove give one result, list gives one result
//   per matching entry in queue order (or a single status result).
// command flow:
//   insert and remove are decided in the accept cycle; the result is valid
//   the next cycle, and a new command can be accepted once it is taken.
//   a list walks the slot chain by rotation, one slot per cycle while the
//   output is free, visiting each occupied slot (up to QUEUE_DEPTH) with
//   s_tready low; the rotation returns every slot to its place.
// reset:
//   queue empty, urgent count zero, id counter at one, no result pending.
// stall:
//   the output register holds a result until m_tready; a pending result
//   freezes the list walk and blocks new commands until it is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_level_priority_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // level[1:0], tag[17:2], zero pad[23:18]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // status[2:0], entry_id[18:3], entry_level[20:19],
                                   // entry_tag[36:21], position[42:37],
                                   // occupancy[49:43], zero pad[55:50]
    output logic        m_tlast
);
    import tlpq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LIST = 2'b10
    } state_t;

    // command fields
    logic [1:0]  in_action;
    logic [1:0]  in_level;
    logic [15:0] in_tag;

    assign in_action = s_tuser;
    assign in_level  = s_tdata[1:0];
    assign in_tag    = s_tdata[17:2];

    // control state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] urgent_reg, urgent_next;
    logic [15:0]      next_id_reg, next_id_next;
    logic [CNT_W-1:0] step_reg, step_next;    // slots walked in the list
    logic [CNT_W-1:0] emit_reg, emit_next;    // matches emitted so far
    logic [CNT_W-1:0] total_reg, total_next;  // matches expected
    logic [1:0]       filter_reg, filter_next;

    // output register
    logic    m_valid_reg, m_valid_next;
    result_t m_data_reg, m_data_next;

    // cell chain
    cell_ctrl_t cell_ctrl;
    entry_t     new_entry;
    entry_t     cell_q [QUEUE_DEPTH];
    entry_t     head;

    logic             out_free;
    logic             in_accept;
    logic [CNT_W-1:0] ins_pos;
    logic [CNT_W-1:0] match_total;
    logic             list_match;

    assign head      = cell_q[0];
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign in_accept = s_tvalid && s_tready;

    assign new_entry.id  = next_id_reg;
    assign new_entry.lvl = in_level;
    assign new_entry.tag = in_tag;

    // urgent entries go behind the last urgent one, normal at the tail
    assign ins_pos = (in_level == LVL_URGENT) ? urgent_reg : count_reg;

    // matches for a list are known up front from the level counts
    always_comb
    begin
        case (in_level)
            LVL_ALL:    match_total = count_reg;
            LVL_URGENT: match_total = urgent_reg;
            LVL_NORMAL: match_total = count_reg - urgent_reg;
            default:    match_total = '0;
        endcase
    end

    assign list_match = (filter_reg == LVL_ALL) || (head.lvl == filter_reg);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        urgent_next  = urgent_reg;
        next_id_next = next_id_reg;
        step_next    = step_reg;
        emit_next    = emit_reg;
        total_next   = total_reg;
        filter_next  = filter_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        cell_ctrl.op   = CELL_HOLD;
        cell_ctrl.pos  = IDX_W'(ins_pos);
        cell_ctrl.tail = IDX_W'(count_reg - 1'b1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    // default: a no-entry result with the current count
                    m_data_next           = '0;
                    m_data_next.occupancy = 7'(count_reg);
                    m_data_next.last      = 1'b1;
                    unique case (in_action)
                        ACT_INSERT:
                        begin
                            m_valid_next = 1'b1;
                            if (count_reg == DEPTH_C)
                            begin
                                m_data_next.status = ST_FULL;
                            end
                            else if (in_level != LVL_URGENT && in_level != LVL_NORMAL)
                            begin
                                m_data_next.status = ST_BADLVL;
                            end
                            else
                            begin
                                cell_ctrl.op            = CELL_INSERT;
                                count_next              = count_reg + 1'b1;
                                next_id_next            = next_id_reg + 16'd1;
                                if (in_level == LVL_URGENT)
                                begin
                                    urgent_next = urgent_reg + 1'b1;
                                end
                                m_data_next.status      = ST_OK;
                                m_data_next.entry_id    = next_id_reg;
                                m_data_next.entry_level = in_level;
                                m_data_next.entry_tag   = in_tag;
                                m_data_next.position    = 6'(ins_pos);
                                m_data_next.occupancy   = 7'(count_reg + 1'b1);
                            end
                        end
                        ACT_REMOVE:
                        begin
                            m_valid_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                m_data_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                cell_ctrl.op            = CELL_REMOVE;
                                count_next              = count_reg - 1'b1;
                                if (head.lvl == LVL_URGENT)
                                begin
                                    urgent_next = urgent_reg - 1'b1;
                                end
                                m_data_next.status      = ST_OK;
                                m_data_next.entry_id    = head.id;
                                m_data_next.entry_level = head.lvl;
                                m_data_next.entry_tag   = head.tag;
                                m_data_next.occupancy   = 7'(count_reg - 1'b1);
                            end
                        end
                        ACT_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                m_valid_next       = 1'b1;
                                m_data_next.status = ST_EMPTY;
                            end
                            else if (match_total == '0)
                            begin
                                m_valid_next       = 1'b1;
                                m_data_next.status = ST_NOMATCH;
                            end
                            else
                            begin
                                state_next  = S_LIST;
                                step_next   = '0;
                                emit_next   = '0;
                                total_next  = match_total;
                                filter_next = in_level;
                            end
                        end
                        default:
                        begin
                            // unused action: no result, no change
                            m_data_next = m_data_reg;
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    // head slot holds the entry at position step_reg
                    cell_ctrl.op = CELL_ROTATE;
                    step_next    = step_reg + 1'b1;
                    if (list_match)
                    begin
                        m_valid_next            = 1'b1;
                        m_data_next.status      = ST_OK;
                        m_data_next.entry_id    = head.id;
                        m_data_next.entry_level = head.lvl;
                        m_data_next.entry_tag   = head.tag;
                        m_data_next.position    = 6'(step_reg);
                        m_data_next.occupancy   = 7'(count_reg);
                        m_data_next.last        = (emit_reg == total_reg - 1'b1);
                        emit_next               = emit_reg + 1'b1;
                    end
                    if (step_reg == count_reg - 1'b1)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            urgent_reg  <= '0;
            next_id_reg <= 16'd1;
            step_reg    <= '0;
            emit_reg    <= '0;
            total_reg   <= '0;
            filter_reg  <= LVL_ALL;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            urgent_reg  <= urgent_next;
            next_id_reg <= next_id_next;
            step_reg    <= step_next;
            emit_reg    <= emit_next;
            total_reg   <= total_next;
            filter_reg  <= filter_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    // slot chain: slot 0 is the queue head
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;

        if (i == 0)
        begin : g_first
            assign left_e = new_entry;  // never selected for slot 0
        end
        else
        begin : g_mid
            assign left_e = cell_q[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_e = cell_q[i];
        end
        else
        begin : g_inner
            assign right_e = cell_q[i+1];
        end

        tlpq_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .left_entry  (left_e),
            .right_entry (right_e),
            .head_entry  (head),
            .new_entry   (new_entry),
            .entry       (cell_q[i])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_data_reg.last;
    assign m_tdata  = {6'd0,
                       m_data_reg.occupancy,
                       m_data_reg.position,
                       m_data_reg.entry_tag,
                       m_data_reg.entry_level,
                       m_data_reg.entry_id,
                       m_data_reg.status};

    // checks on internal bookkeeping
    `TLPQ_ASSERT(a_count_bound, count_reg <= DEPTH_C)
    `TLPQ_ASSERT(a_urgent_bound, urgent_reg <= count_reg)
    `TLPQ_ASSERT_IMP(a_list_blocks_input, state_reg == S_LIST, !s_tready)
    `TLPQ_ASSERT_IMP(a_error_is_last, m_valid_reg && m_data_reg.status != ST_OK,
                     m_data_reg.last)

endmodule

// ===== hw/rtl/tlpq_cell.sv =====
// ----------------------------------------------------------------------------
// tlpq_cell
// one queue slot; shifts toward the tail on insert, toward the head on
// remove, and rotates the occupied run during a list walk
// ----------------------------------------------------------------------------
module tlpq_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                clk,
    input  tlpq_pkg::cell_ctrl_t ctrl,
    input  tlpq_pkg::entry_t    left_entry,   // slot nearer the head
    input  tlpq_pkg::entry_t    right_entry,  // slot nearer the tail
    input  tlpq_pkg::entry_t    head_entry,
    input  tlpq_pkg::entry_t    new_entry,
    output tlpq_pkg::entry_t    entry
);
    import tlpq_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            CELL_INSERT:
            begin
                if (MY_IDX == ctrl.pos)
                begin
                    entry_next = new_entry;
                end
                else if (MY_IDX > ctrl.pos)
                begin
                    entry_next = left_entry;
                end
            end
            CELL_REMOVE:
            begin
                entry_next = right_entry;
            end
            CELL_ROTATE:
            begin
                // tail slot wraps around to take the old head
                entry_next = (MY_IDX == ctrl.tail) ? head_entry : right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
